@@ hw/rtl/mte_pkg.sv @@
// Shared types, constants and helper functions for the multi-tap feedback echo.
// Used by the stream interfaces and by every module of the block; no dependencies.
`default_nettype none

package mte_pkg;

  // Sample format: signed Q1.23.
  localparam int unsigned SAMPLE_BITS = 24;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_DELAY = 65536;
  localparam int unsigned DEF_UNITS = 4;

  // Configuration port.
  localparam int unsigned UNIT_REGS = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;

  // Output buffer depth, also the number of words allowed in flight.
  localparam int unsigned OUT_DEPTH = 8;

  // Fixed-point scaling.
  localparam int unsigned Q14_SHIFT = 14;
  localparam int unsigned LINE_SHIFT = 30;
  localparam int unsigned MIX_SHIFT = 12;
  localparam int unsigned SAT_IN_W = 48;
  localparam logic signed [16:0] UNITY_Q14 = 17'sd16384;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT0,
    REG_UNIT1,
    REG_UNIT2,
    REG_UNIT3,
    REG_ECHO_GAIN,
    REG_DIRECT_GAIN,
    REG_STEREO_MODE
  } cfg_reg_e;

  // Packed layout of one unit settings register.
  typedef struct packed {
    logic signed [15:0] pan;       // Q1.14
    logic [15:0]        feedback;  // Q0.16
    logic [15:0]        level;     // Q0.16
    logic [15:0]        length;    // samples, zero means silent
  } unit_cfg_t;

  // Status a lane reports to the input handshake.
  typedef struct packed {
    logic clearing;
    logic hazard;
  } lane_stat_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  function automatic sample_t sat_sample(input logic signed [SAT_IN_W-1:0] x);
    if (x > SAT_IN_W'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (x < SAT_IN_W'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

  // Pan factor in Q1.14 for one channel; mono always gets unity.
  function automatic logic signed [15:0] pan_factor(input logic signed [15:0] pan,
                                                    input logic stereo,
                                                    input logic right);
    logic signed [16:0] f;
    f = UNITY_Q14;
    if (stereo) begin
      if (!right && pan > 16'sd0) begin
        f = UNITY_Q14 - 17'(pan);
      end else if (right && pan < 16'sd0) begin
        f = UNITY_Q14 + 17'(pan);
      end
    end
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mte_stream_if.sv @@
// Valid/ready stream interfaces for the echo block's input and output words.
// Depends on mte_pkg for the sample type.
`default_nettype none

interface mte_in_if import mte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_left;
  sample_t in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface mte_out_if import mte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/multi_tap_feedback_echo.sv @@
// Multi-tap feedback echo: top level with configuration registers, echo lanes,
// merge stage and output buffer. Depends on mte_pkg, mte_stream_if, mte_lane,
// mte_mix and mte_ofifo.
//
// Usage: each input word on in_i carries one stereo pair (or a mono sample in
// in_left) in signed Q1.23; each output word on out_o carries the mixed pair,
// saturated to 24 bits, with out_right held at zero in mono. Both channels use
// valid/ready; a word moves at a rising edge with valid and ready high.
// Settings are written through cfg_we_i/cfg_idx_i/cfg_data_i while no word is
// in flight. An accepted word passes the lane read register, then the merge
// stage's sum and gain registers and the output buffer on its way to out_o.
// The block takes one word per cycle while nothing below holds input off.
// When a unit's length is one or two samples, the read of a position waits
// for the write-back of the previous pass through the two-stage feedback
// pipeline, so input slows for those lengths. A write that changes a unit's
// length holds off input while that unit zeroes its lines, one entry per cycle.
// Reset zeroes all lengths and positions and loads the default gains; no
// memory sweep runs at reset since a unit with length zero reads nothing.
// When the receiver stalls, results collect in an eight-word output buffer and
// input ready drops once eight words are outstanding.
`default_nettype none

module multi_tap_feedback_echo import mte_pkg::*; #(
  parameter int unsigned MAX_DELAY = DEF_MAX_DELAY,
  parameter int unsigned UNITS = DEF_UNITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mte_in_if.sink                     in_i,
  mte_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  // Configuration registers.
  unit_cfg_t         unit_cfg_q [UNIT_REGS];
  logic [GAIN_W-1:0] echo_gain_q;
  logic [GAIN_W-1:0] direct_gain_q;
  logic              stereo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UNIT_REGS; i++) begin
        unit_cfg_q[i] <= '0;
      end
      echo_gain_q   <= GAIN_RST;
      direct_gain_q <= GAIN_RST;
      stereo_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UNIT0:       unit_cfg_q[0] <= cfg_data_i;
        REG_UNIT1:       unit_cfg_q[1] <= cfg_data_i;
        REG_UNIT2:       unit_cfg_q[2] <= cfg_data_i;
        REG_UNIT3:       unit_cfg_q[3] <= cfg_data_i;
        REG_ECHO_GAIN:   echo_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_DIRECT_GAIN: direct_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_STEREO_MODE: stereo_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  logic       in_rdy, accept, pop;
  logic       any_clearing, any_hazard;
  lane_stat_t lane_stat [UNITS];

  assign accept = in_i.valid && in_rdy;

  // Echo lanes. Units without a settings register stay silent.
  sample_t old_l [UNITS];
  sample_t old_r [UNITS];

  for (genvar u = 0; u < UNITS; u++) begin : g_lane
    unit_cfg_t lane_cfg;
    if (u < UNIT_REGS) begin : g_reg
      assign lane_cfg = unit_cfg_q[u];
    end else begin : g_none
      assign lane_cfg = '0;
    end

    mte_lane #(
      .MAX_DELAY (MAX_DELAY)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .settings_i  (lane_cfg),
      .stereo_i    (stereo_q),
      .accept_i    (accept),
      .in_left_i   (in_i.in_left),
      .in_right_i  (in_i.in_right),
      .old_left_o  (old_l[u]),
      .old_right_o (old_r[u]),
      .stat_o      (lane_stat[u])
    );
  end

  always_comb begin
    any_clearing = 1'b0;
    any_hazard   = 1'b0;
    for (int u = 0; u < UNITS; u++) begin
      any_clearing = any_clearing | lane_stat[u].clearing;
      any_hazard   = any_hazard | lane_stat[u].hazard;
    end
  end

  // Merge the lanes and mix in the dry signal.
  logic   res_vld;
  frame_t res;

  mte_mix #(
    .UNITS (UNITS)
  ) u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_left_i     (in_i.in_left),
    .in_right_i    (in_i.in_right),
    .old_left_i    (old_l),
    .old_right_i   (old_r),
    .echo_gain_i   (echo_gain_q),
    .direct_gain_i (direct_gain_q),
    .stereo_i      (stereo_q),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  // Output buffer.
  logic   out_vld;
  frame_t out_data;

  mte_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (out_vld),
    .data_o  (out_data)
  );

  assign out_o.valid     = out_vld;
  assign out_o.out_left  = out_data.left;
  assign out_o.out_right = out_data.right;
  assign pop             = out_vld && out_o.ready;

  // Words accepted but not yet delivered; this bounds what the buffer must hold,
  // so ready never depends on the receiver within the same cycle.
  logic [CNT_W-1:0] cnt_d, cnt_q;

  always_comb begin
    unique case ({accept, pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign in_rdy   = (cnt_q < CNT_W'(OUT_DEPTH)) && !any_clearing && !any_hazard;
  assign in_i.ready = in_rdy;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_DEPTH))
    else $error("outstanding word count exceeds the buffer depth");

  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld |-> (cnt_q != '0))
    else $error("output word present with no word outstanding");

endmodule

`default_nettype wire

@@ hw/rtl/mte_lane.sv @@
// One echo unit: left and right delay memories, feedback write-back pipeline
// and the clearing sweep after a length change. Depends on mte_pkg.
`default_nettype none

module mte_lane import mte_pkg::*; #(
  parameter int unsigned MAX_DELAY = DEF_MAX_DELAY
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire unit_cfg_t  settings_i,
  input  wire logic       stereo_i,
  input  wire logic       accept_i,
  input  wire sample_t    in_left_i,
  input  wire sample_t    in_right_i,
  output sample_t         old_left_o,
  output sample_t         old_right_o,
  output lane_stat_t      stat_o
);

  localparam int unsigned LEN_W = $clog2(MAX_DELAY + 1);
  localparam int unsigned ADDR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned LF_W = 33;
  localparam int unsigned P1_W = SAMPLE_BITS + LF_W;
  localparam int unsigned P2_W = SAMPLE_BITS + 17;
  localparam int unsigned ACC_W = P1_W + 1;
  localparam logic signed [ACC_W-1:0] LINE_HALF = ACC_W'(1) << (LINE_SHIFT - 1);

  // Delay memories, one per channel.
  sample_t mem_l [MAX_DELAY];
  sample_t mem_r [MAX_DELAY];

  logic [LEN_W-1:0]  len_eff, len_d, len_q;
  logic [ADDR_W-1:0] pos_d, pos_q;
  logic [ADDR_W-1:0] clr_cnt_d, clr_cnt_q, clr_last;
  logic              clear_d, clear_q;
  logic              len_chg, active, pos_wrap;
  logic [LEN_W-1:0]  pos_inc;

  logic signed [LF_W-1:0] lf_q [2];

  logic              s1_vld_q, s1_act_q;
  logic [ADDR_W-1:0] s1_pos_q;
  sample_t           s1_in_q [2];
  sample_t           rd_q [2];

  logic                   s2_vld_q, s2_act_q;
  logic [ADDR_W-1:0]      s2_pos_q;
  logic signed [P1_W-1:0] s2_p1_q [2];
  logic signed [P2_W-1:0] s2_p2_q [2];

  logic signed [ACC_W-1:0] acc [2];
  sample_t                 new_smp [2];
  logic [1:0]              wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  sample_t                 wr_data [2];

  always_comb begin
    if (32'(settings_i.length) > 32'(MAX_DELAY)) begin
      len_eff = LEN_W'(MAX_DELAY);
    end else begin
      len_eff = LEN_W'(settings_i.length);
    end
  end

  assign len_chg  = (len_eff != len_q);
  assign active   = (len_q != '0);
  assign pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
  assign pos_wrap = (pos_inc >= len_q);
  assign clr_last = ADDR_W'(len_q - LEN_W'(1));

  // A new length restarts the line at position zero and zeroes it first.
  always_comb begin
    len_d     = len_q;
    pos_d     = pos_q;
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (len_chg) begin
      len_d     = len_eff;
      pos_d     = '0;
      clear_d   = (len_eff != '0);
      clr_cnt_d = '0;
    end else if (clear_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == clr_last) begin
        clear_d = 1'b0;
      end
    end else if (accept_i && active) begin
      pos_d = pos_wrap ? '0 : pos_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pos_q     <= '0;
      clear_q   <= 1'b0;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      len_q     <= len_d;
      pos_q     <= pos_d;
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
      s1_vld_q  <= accept_i;
      s2_vld_q  <= s1_vld_q;
    end
  end

  // Level times pan factor only changes with the settings.
  always_ff @(posedge clk_i) begin
    lf_q[0] <= $signed({1'b0, settings_i.level}) * pan_factor(settings_i.pan, stereo_i, 1'b0);
    lf_q[1] <= $signed({1'b0, settings_i.level}) * pan_factor(settings_i.pan, stereo_i, 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_act_q   <= active;
      s1_pos_q   <= pos_q;
      s1_in_q[0] <= in_left_i;
      s1_in_q[1] <= in_right_i;
    end
    s2_act_q <= s1_act_q;
    s2_pos_q <= s1_pos_q;
    for (int c = 0; c < 2; c++) begin
      s2_p1_q[c] <= s1_in_q[c] * lf_q[c];
      s2_p2_q[c] <= rd_q[c] * $signed({1'b0, settings_i.feedback});
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      acc[c] = ACC_W'(s2_p1_q[c]) + (ACC_W'(s2_p2_q[c]) <<< Q14_SHIFT) + LINE_HALF;
      new_smp[c] = sat_sample(SAT_IN_W'(acc[c] >>> LINE_SHIFT));
      wr_data[c] = clear_q ? '0 : new_smp[c];
    end
  end

  // The right line takes no write-back in mono; the clearing sweep still zeroes it.
  assign wr_en[0] = clear_q || (s2_vld_q && s2_act_q);
  assign wr_en[1] = clear_q || (s2_vld_q && s2_act_q && stereo_i);
  assign wr_addr  = clear_q ? clr_cnt_q : s2_pos_q;

  always_ff @(posedge clk_i) begin
    if (wr_en[0]) begin
      mem_l[wr_addr] <= wr_data[0];
    end
    rd_q[0] <= mem_l[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en[1]) begin
      mem_r[wr_addr] <= wr_data[1];
    end
    rd_q[1] <= mem_r[pos_q];
  end

  assign old_left_o  = s1_act_q ? rd_q[0] : '0;
  assign old_right_o = s1_act_q ? rd_q[1] : '0;

  // The read position must not still be waiting for its write-back.
  assign stat_o.clearing = clear_q || len_chg;
  assign stat_o.hazard   = active && ((s1_vld_q && (s1_pos_q == pos_q)) ||
                                      (s2_vld_q && (s2_pos_q == pos_q)));

  a_clear_vs_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clear_q && s2_vld_q))
    else $error("lane clearing sweep overlaps a pending write-back");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (LEN_W'(pos_q) < len_q))
    else $error("lane position beyond its length");

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !clear_q)
    else $error("word accepted while the lane is clearing");

endmodule

`default_nettype wire

@@ hw/rtl/mte_mix.sv @@
// Merge stage: sums the old samples of all lanes and mixes them with the dry
// input through the echo and direct gains. Depends on mte_pkg.
`default_nettype none

module mte_mix import mte_pkg::*; #(
  parameter int unsigned UNITS = DEF_UNITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire sample_t           in_left_i,
  input  wire sample_t           in_right_i,
  input  wire sample_t           old_left_i [UNITS],
  input  wire sample_t           old_right_i [UNITS],
  input  wire logic [GAIN_W-1:0] echo_gain_i,
  input  wire logic [GAIN_W-1:0] direct_gain_i,
  input  wire logic              stereo_i,
  output logic                   res_vld_o,
  output frame_t                 res_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(UNITS + 1);
  localparam int unsigned EG_W = SUM_W + GAIN_W + 1;
  localparam int unsigned DG_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int unsigned MIX_W = EG_W + 1;
  localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(1) << (MIX_SHIFT - 1);

  logic    s1_vld_q, m2_vld_q, m3_vld_q;
  sample_t s1_in_q [2];
  sample_t m2_in_q [2];

  logic signed [SUM_W-1:0] sum_d [2];
  logic signed [SUM_W-1:0] m2_sum_q [2];
  logic signed [EG_W-1:0]  m3_eg_q [2];
  logic signed [DG_W-1:0]  m3_dg_q [2];
  logic signed [MIX_W-1:0] acc [2];
  sample_t                 mixed [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
      m2_vld_q <= s1_vld_q;
      m3_vld_q <= m2_vld_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sum_d[c] = '0;
    end
    for (int u = 0; u < UNITS; u++) begin
      sum_d[0] = sum_d[0] + SUM_W'(old_left_i[u]);
      sum_d[1] = sum_d[1] + SUM_W'(old_right_i[u]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_in_q[0] <= in_left_i;
      s1_in_q[1] <= in_right_i;
    end
    for (int c = 0; c < 2; c++) begin
      m2_in_q[c]  <= s1_in_q[c];
      m2_sum_q[c] <= sum_d[c];
      m3_eg_q[c]  <= m2_sum_q[c] * $signed({1'b0, echo_gain_i});
      m3_dg_q[c]  <= m2_in_q[c] * $signed({1'b0, direct_gain_i});
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      acc[c]   = MIX_W'(m3_eg_q[c]) + MIX_W'(m3_dg_q[c]) + MIX_HALF;
      mixed[c] = sat_sample(SAT_IN_W'(acc[c] >>> MIX_SHIFT));
    end
  end

  assign res_vld_o   = m3_vld_q;
  assign res_o.left  = mixed[0];
  assign res_o.right = stereo_i ? mixed[1] : '0;

endmodule

`default_nettype wire

@@ hw/rtl/mte_ofifo.sv @@
// Output word buffer that decouples the mixing pipeline from the receiver.
// Depends on mte_pkg for the frame type and depth.
`default_nettype none

module mte_ofifo import mte_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t data_i,
  input  wire logic   pop_i,
  output logic        valid_o,
  output frame_t      data_o
);

  localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  frame_t           mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CNT_W'(OUT_DEPTH)))
    else $error("output buffer written while full");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for multi_tap_feedback_echo: a directed table, then random phases
// of settings and sample words, scored against an untimed echo model or typed results.
// Depends on mte_pkg, the mte stream interfaces and the block's RTL.

module testbench;
  import mte_pkg::*;

  localparam int unsigned UNITS = DEF_UNITS;
  localparam int unsigned MAX_DELAY = DEF_MAX_DELAY;

  // Index seven is decoded by nothing; writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned RANDOM_WORDS = 1950;
  // The last words of the run go through with neither side idling.
  localparam int unsigned QUIET_TAIL = 200;
  // A long line costs one cycle per entry to clear, so only a few random ones are allowed.
  localparam int unsigned MAX_LONG_LINES = 4;
  localparam int unsigned DRAIN_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PRINT_CAP = 100;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_WORD,
    ROW_FIXED
  } row_kind_e;

  // One line of the directed table: a register write, a word checked by the model, or a
  // word whose result is typed into the table.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    frame_t                stim;
    frame_t                want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mte_in_if  in_if ();
  mte_out_if out_if ();

  multi_tap_feedback_echo #(
    .MAX_DELAY(MAX_DELAY),
    .UNITS(UNITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Model state: the delay lines of every unit and channel, the shared write position and
  // effective length of each unit, and a shadow copy of every setting register.
  sample_t           line_mem [UNITS][2][MAX_DELAY];
  int unsigned       line_pos [UNITS];
  int unsigned       line_len [UNITS];
  unit_cfg_t         unit_set [UNIT_REGS];
  logic [GAIN_W-1:0] echo_gain_r;
  logic [GAIN_W-1:0] direct_gain_r;
  logic              stereo_r;

  frame_t      expected_frames [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned long_lines = 0;
  bit          idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Safety net well beyond the slowest legal run, long clears included.
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Echo model
  // ---------------------------------------------------------------------------------------

  function automatic sample_t clamp_q23(input longint x);
    if (x > longint'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (x < longint'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

  // Round half up: add half an LSB of the result, then floor through the arithmetic shift.
  function automatic longint round_q(input longint x, input int unsigned s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Runs one channel through every active unit. Each unit returns its oldest sample into the
  // echo sum and then overwrites it with the panned input plus the fed-back old sample.
  function automatic longint echo_channel(input longint x, input int chan, input bit panned);
    longint sum;
    longint old;
    longint lvl;
    longint fb;
    longint pan;
    longint unity;
    longint f;
    longint acc;
    int     u;
    sum = 0;
    unity = UNITY_Q14;
    for (u = 0; u < UNITS; u++) begin
      if (line_len[u] == 0) begin
        continue;
      end
      old = line_mem[u][chan][line_pos[u]];
      lvl = unit_set[u].level;
      fb = unit_set[u].feedback;
      pan = $signed(unit_set[u].pan);
      // Panning only attenuates the far side: positive pan cuts the left, negative the right.
      if (!panned) begin
        f = unity;
      end else if (chan == 0) begin
        f = (pan <= 0) ? unity : unity - pan;
      end else begin
        f = (pan >= 0) ? unity : unity + pan;
      end
      sum += old;
      acc = x * lvl * f + old * fb * (longint'(1) <<< Q14_SHIFT);
      line_mem[u][chan][line_pos[u]] = clamp_q23(round_q(acc, LINE_SHIFT));
    end
    return sum;
  endfunction

  function automatic sample_t mix_q23(input longint echo_sum, input longint dry);
    longint eg;
    longint dg;
    eg = echo_gain_r;
    dg = direct_gain_r;
    return clamp_q23(round_q(echo_sum * eg + dry * dg, MIX_SHIFT));
  endfunction

  // Result word for one input word; also advances the model by one sample period.
  function automatic frame_t predict_frame(input frame_t w);
    frame_t r;
    longint dl;
    longint dr;
    longint sl;
    longint sr;
    int     u;
    dl = $signed(w.left);
    dr = $signed(w.right);
    if (stereo_r) begin
      sl = echo_channel(dl, 0, 1'b1);
      sr = echo_channel(dr, 1, 1'b1);
      r.left = mix_q23(sl, dl);
      r.right = mix_q23(sr, dr);
    end else begin
      // Mono leaves the right lines untouched and holds the right output at zero.
      sl = echo_channel(dl, 0, 1'b0);
      r.left = mix_q23(sl, dl);
      r.right = '0;
    end
    for (u = 0; u < UNITS; u++) begin
      if (line_len[u] != 0) begin
        line_pos[u] = (line_pos[u] + 1 >= line_len[u]) ? 0 : line_pos[u] + 1;
      end
    end
    return r;
  endfunction

  function automatic void reset_model();
    int u;
    int c;
    int i;
    for (u = 0; u < UNITS; u++) begin
      for (c = 0; c < 2; c++) begin
        for (i = 0; i < MAX_DELAY; i++) begin
          line_mem[u][c][i] = '0;
        end
      end
      line_pos[u] = 0;
      line_len[u] = 0;
    end
    for (u = 0; u < UNIT_REGS; u++) begin
      unit_set[u] = '0;
    end
    echo_gain_r = GAIN_RST;
    direct_gain_r = GAIN_RST;
    stereo_r = 1'b0;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    int unsigned u;
    int unsigned nl;
    int unsigned span;
    int unsigned i;
    case (idx)
      REG_UNIT0, REG_UNIT1, REG_UNIT2, REG_UNIT3: begin
        u = idx;
        unit_set[u] = data;
        nl = data[15:0];
        if (nl > MAX_DELAY) begin
          nl = MAX_DELAY;
        end
        // Only a change of length wipes the unit. Clearing up to the longer of the two
        // lengths keeps every entry past the current length at zero.
        if (nl != line_len[u]) begin
          span = (nl > line_len[u]) ? nl : line_len[u];
          for (i = 0; i < span; i++) begin
            line_mem[u][0][i] = '0;
            line_mem[u][1][i] = '0;
          end
          line_len[u] = nl;
          line_pos[u] = 0;
        end
      end
      REG_ECHO_GAIN: begin
        echo_gain_r = data[GAIN_W-1:0];
      end
      REG_DIRECT_GAIN: begin
        direct_gain_r = data[GAIN_W-1:0];
      end
      REG_STEREO_MODE: begin
        stereo_r = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic logic [CFG_DATA_W-1:0] pack_unit(input logic [15:0] len,
                                                      input logic [15:0] lvl,
                                                      input logic [15:0] fb,
                                                      input logic [15:0] pan);
    unit_cfg_t c;
    c.length = len;
    c.level = lvl;
    c.feedback = fb;
    c.pan = pan;
    return c;
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void word_row(input sample_t l, input sample_t rt);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.stim.left = l;
    r.stim.right = rt;
    directed_rows.push_back(r);
  endfunction

  function automatic void fixed_row(input sample_t l, input sample_t rt,
                                    input sample_t wl, input sample_t wr);
    stim_row_t r;
    r.kind = ROW_FIXED;
    r.idx = '0;
    r.data = '0;
    r.stim.left = l;
    r.stim.right = rt;
    r.want.left = wl;
    r.want.right = wr;
    directed_rows.push_back(r);
  endfunction

  // Mostly random, with the corners of a 16-bit field showing up a quarter of the time.
  function automatic logic [15:0] random_field();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h8000;
        default: return 16'h7FFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Short lines dominate so echoes come back many times within a phase; one and two sample
  // lines exercise the read-after-write stall; a handful of long lines cover the top bits.
  function automatic logic [CFG_DATA_W-1:0] random_unit();
    unit_cfg_t   c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      c.length = 16'd0;
    end else if (pick < 30) begin
      c.length = 16'($urandom_range(1, 2));
    end else if (pick < 80) begin
      c.length = 16'($urandom_range(3, 24));
    end else if (pick < 97 || long_lines >= MAX_LONG_LINES) begin
      c.length = 16'($urandom_range(25, 400));
    end else begin
      c.length = (pick == 99) ? 16'hFFFF : 16'($urandom);
      long_lines++;
    end
    c.level = random_field();
    c.feedback = random_field();
    c.pan = random_field();
    return c;
  endfunction

  // Gains carry junk in the unused upper data bits, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] random_gain();
    logic [GAIN_W-1:0] g;
    if ($urandom_range(0, 3) == 0) begin
      g = random_field();
    end else begin
      g = 16'($urandom_range(0, 8192));
    end
    return {32'($urandom), 16'($urandom), g};
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return -24'sd1;
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  // Each register write drops cfg_we again before the task returns; the model takes the write as the block does.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    apply_setting(idx, data);
    @(posedge clk_i);
  endtask

  // Every word causes exactly one result, so an empty expectation queue means the block
  // holds nothing in flight and settings may change.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Presents one word and returns at the edge that accepts it. Valid is left high so that a
  // following word goes out back to back; the caller lowers it for a gap.
  task automatic send_word(input frame_t w, input bit fixed, input frame_t want);
    frame_t model_out;
    in_if.valid <= 1'b1;
    in_if.in_left <= w.left;
    in_if.in_right <= w.right;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    model_out = predict_frame(w);
    expected_frames.push_back(fixed ? want : model_out);
  endtask

  task automatic source_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic randomize_settings();
    int i;
    for (i = 0; i < UNIT_REGS; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_IDX_W'(REG_UNIT0 + i), random_unit());
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_ECHO_GAIN, random_gain());
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_DIRECT_GAIN, random_gain());
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_STEREO_MODE, {32'($urandom), 31'($urandom), 1'($urandom_range(0, 1))});
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side: random stalls on ready, and the scoreboard on accepted words.
  // ---------------------------------------------------------------------------------------

  // A stall drops ready and holds it low while a random hold count runs down; outside idling phases ready stays high.
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(0, 8);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Values seen here are those from before the edge, since every driver on both sides
  // updates with nonblocking assignments.
  always @(posedge clk_i) begin : check_out
    frame_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("word with no input behind it: left %0d right %0d",
                                  out_if.out_left, out_if.out_right));
      end else begin
        want = expected_frames.pop_front();
        if (out_if.out_left !== want.left) begin
          report_mismatch($sformatf("out_left is %0d, model says %0d",
                                    out_if.out_left, want.left));
        end
        if (out_if.out_right !== want.right) begin
          report_mismatch($sformatf("out_right is %0d, model says %0d",
                                    out_if.out_right, want.right));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    stim_row_t   row;
    int unsigned sent;
    int unsigned burst;
    int unsigned waited;
    frame_t      no_want;

    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.in_left <= '0;
    in_if.in_right <= '0;
    no_want = '0;
    reset_model();

    // After reset every unit is silent, mono is selected and both gains are unity, so each
    // word passes through unchanged on the left with zero on the right.
    fixed_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, '0);
    fixed_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, '0);
    fixed_row('0, -24'sd1, '0, '0);
    fixed_row(-24'sd1, 24'sd1, -24'sd1, '0);
    // Stereo with no units: both channels pass straight through.
    reg_row(REG_STEREO_MODE, 64'd1);
    fixed_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    fixed_row(24'sd1, -24'sd1, 24'sd1, -24'sd1);
    // Largest dry gain drives full-scale input into saturation on both rails.
    reg_row(REG_DIRECT_GAIN, 64'hFFFF);
    fixed_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    // Zero dry gain with no echoes gives silence.
    reg_row(REG_DIRECT_GAIN, 64'd0);
    fixed_row(SAMPLE_MAX, SAMPLE_MIN, '0, '0);
    // Shortest lines, one with full level and feedback, both pan extremes, a silent unit that
    // still carries nonzero level, and the largest echo gain.
    reg_row(REG_UNIT0, pack_unit(16'd1, 16'hFFFF, 16'hFFFF, 16'h0000));
    reg_row(REG_UNIT1, pack_unit(16'd2, 16'h8000, 16'hC000, 16'h7FFF));
    reg_row(REG_UNIT2, pack_unit(16'd3, 16'hFFFF, 16'h4000, 16'h8000));
    reg_row(REG_UNIT3, pack_unit(16'd0, 16'hFFFF, 16'hFFFF, 16'h2000));
    reg_row(REG_ECHO_GAIN, 64'hFFFF);
    reg_row(REG_DIRECT_GAIN, 64'd4096);
    word_row(SAMPLE_MAX, SAMPLE_MIN);
    word_row(SAMPLE_MIN, SAMPLE_MAX);
    word_row(SAMPLE_MAX, SAMPLE_MAX);
    word_row('0, '0);
    word_row(SAMPLE_MIN, SAMPLE_MIN);
    word_row(24'sh123456, -24'sh345678);
    // Same length with new level keeps the line; a new length wipes it; the unused index
    // changes nothing.
    reg_row(REG_UNIT0, pack_unit(16'd1, 16'h1234, 16'h0000, 16'h0000));
    reg_row(REG_UNIT1, pack_unit(16'd5, 16'hFFFF, 16'h8000, 16'hC000));
    reg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    // Back to mono: pan is ignored and the right lines keep their content.
    reg_row(REG_STEREO_MODE, 64'd0);
    word_row(SAMPLE_MAX, SAMPLE_MAX);
    word_row(-24'sh400000, 24'sh7FFFFF);
    word_row('0, SAMPLE_MIN);
    word_row(24'sh0ABCDE, '0);
    reg_row(REG_STEREO_MODE, 64'd1);
    word_row(24'sh200000, -24'sh200000);
    word_row('0, '0);
    word_row(-24'sd1, 24'sd1);
    // Longest line the length field can hold; the block stalls input while it clears.
    reg_row(REG_UNIT3, pack_unit(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h0001));
    word_row(SAMPLE_MAX, SAMPLE_MIN);
    word_row(24'sh55AA55, -24'sh2AA55A);
    word_row('0, '0);
    reg_row(REG_UNIT3, pack_unit(16'd0, 16'h0000, 16'h0000, 16'h0000));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_REG: begin
          wait_idle();
          write_reg(row.idx, row.data);
        end
        ROW_WORD: begin
          send_word(row.stim, 1'b0, no_want);
          source_gap();
        end
        default: begin
          send_word(row.stim, 1'b1, row.want);
          source_gap();
        end
      endcase
    end

    // Random phases: settle, change a random subset of settings, then stream a burst of
    // words. Most phases idle on both sides; some run flat out; the tail never idles.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      randomize_settings();
      burst = $urandom_range(40, 160);
      if (burst > RANDOM_WORDS - sent) begin
        burst = RANDOM_WORDS - sent;
      end
      idle_on = (RANDOM_WORDS - sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        send_word('{left: random_sample(), right: random_sample()}, 1'b0, no_want);
        source_gap();
        sent++;
      end
    end

    // Drain: every word still owed must come back, then a few more cycles catch strays.
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_frames.size() != 0) begin
      report_mismatch($sformatf("%0d words never came back", expected_frames.size()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mte_pkg.sv
hw/rtl/mte_stream_if.sv
hw/rtl/mte_lane.sv
hw/rtl/mte_mix.sv
hw/rtl/mte_ofifo.sv
hw/rtl/multi_tap_feedback_echo.sv
sim/testbench.sv
